// File: hdl/hbie_pkg.sv
// shared types and constants of the histogram bar image engine
package hbie_pkg;

   localparam int Q_W      = 10;
   localparam int NUM_W    = 41;
   localparam int DEN_W    = 32;
   localparam int DIVCNT_W = $clog2(Q_W);

   localparam int NUM_BINS_RST = 100;
   localparam int IMG_LEN_RST  = 300;
   localparam int IMG_WID_RST  = 300;

   localparam logic [7:0] PIX_INSIDE     = 8'd0;
   localparam logic [7:0] PIX_BACKGROUND = 8'd255;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_BIN   = 2'd1,
      REQ_PIXEL = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_NOHIST = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_NUM_BINS = 2'd0,
      CSR_IMG_LEN  = 2'd1,
      CSR_IMG_WID  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_BIN    = 2'd0,
      DIV_BAR    = 2'd1,
      DIV_STRIPE = 2'd2,
      DIV_ROW    = 2'd3
   } div_sel_type;

   typedef enum logic [2:0] {
      RSP_NONE  = 3'd0,
      RSP_PRE   = 3'd1,
      RSP_LOAD  = 3'd2,
      RSP_BLANK = 3'd3,
      RSP_BAR   = 3'd4
   } rsp_op_type;

   typedef struct packed {
      logic        accept;
      logic        clr_step;
      logic        idx_clear;
      logic        idx_inc;
      logic        mm_upd;
      logic        bn_off;
      logic        bn_mul;
      logic        bc_write;
      logic        finish;
      logic        br_mul;
      logic        bin_rd_bar;
      logic        div_start;
      div_sel_type div_sel;
      rsp_op_type  rsp_op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       last;
      status_type pre_status;
      logic       total_zero;
      logic       idx_last;
      logic       clr_last;
      logic       span_zero;
      logic       peak_zero;
      logic       stripe_zero;
      logic       k_out;
      logic       div_done;
   } stat_type;

endpackage

// File: hdl/hbie_div.sv
// restoring divider, one quotient bit per cycle
module hbie_div
   import hbie_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo,
   output logic             done
);

   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [Q_W-1:0]      quo_ff, quo_in;
   logic [DIVCNT_W-1:0] bit_ff, bit_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [NUM_W-1:0]    shifted;
   logic                fit;

   assign shifted = NUM_W'(den_ff) << bit_ff;
   assign fit     = rem_ff >= shifted;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         den_in = den;
         quo_in = '0;
         bit_in = DIVCNT_W'(Q_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (fit) begin
            rem_in         = rem_ff - shifted;
            quo_in[bit_ff] = 1'b1;
         end
         if (bit_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

// File: hdl/hbie_datapath.sv
// sample store, bin counters, min/max, bar arithmetic and result registers
module hbie_datapath
   import hbie_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int MAX_BINS    = 256,
   parameter int CNT_W       = 13
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          st,
   input  logic [1:0]        req_type,
   input  logic [31:0]       req_sample_value,
   input  logic              req_last_sample,
   input  logic [7:0]        req_bin_index,
   input  logic [9:0]        req_pixel_row,
   input  logic [9:0]        req_pixel_col,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_wdata,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [CNT_W-1:0]  rsp_bin_count,
   output logic [9:0]        rsp_bar_height,
   output logic [7:0]        rsp_pixel_value,
   output logic [31:0]       rsp_min_value,
   output logic [31:0]       rsp_max_value,
   output logic [CNT_W-1:0]  rsp_max_count
);

   localparam int SA_W = $clog2(MAX_SAMPLES);
   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int BP_W = CNT_W + 10;
   localparam int D5_W = CNT_W + 3;

   logic [31:0]      store_mem [MAX_SAMPLES];
   logic [31:0]      store_rdata_ff;
   logic [CNT_W-1:0] bin_mem [MAX_BINS];
   logic [CNT_W-1:0] bin_rdata_ff;

   logic [8:0]       num_bins_ff, num_bins_in;
   logic [9:0]       img_len_ff, img_len_in;
   logic [9:0]       img_wid_ff, img_wid_in;
   logic             ready_ff, ready_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [BIN_W-1:0] clr_ff, clr_in;
   logic [31:0]      lo_ff, lo_in;
   logic [31:0]      hi_ff, hi_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [31:0]      off_ff, off_in;
   logic [31:0]      span_ff, span_in;
   logic             span_zero_ff, span_zero_in;
   logic [NUM_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [BP_W-1:0]  bprod_ff, bprod_in;
   logic [D5_W-1:0]  den5_ff, den5_in;
   logic [1:0]       type_ff, type_in;
   logic [7:0]       bidx_ff, bidx_in;
   logic [9:0]       row_ff, row_in;
   logic [9:0]       col_ff, col_in;
   logic             full_st_ff, full_st_in;
   logic             strobe_ff, strobe_in;
   logic [1:0]       status_ff, status_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [9:0]       height_ff, height_in;
   logic [7:0]       pixel_ff, pixel_in;

   logic [8:0]       m_value;
   logic             full;
   status_type       pre_status;
   logic             store_we;
   logic [Q_W-1:0]   quo;
   logic             div_done;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [Q_W-1:0]   bin_q;
   logic [BIN_W-1:0] bin_rd_addr;
   logic [BIN_W-1:0] bin_wr_addr;
   logic [CNT_W-1:0] bin_wr_data;
   logic             bin_we;
   logic [CNT_W-1:0] inc_count;
   logic [32:0]      off_full;
   logic [32:0]      span_full;
   logic [9:0]       bar_h;

   always_comb begin
      if (num_bins_ff == '0) begin
         m_value = 9'd1;
      end else if (int'(num_bins_ff) > MAX_BINS) begin
         m_value = 9'(MAX_BINS);
      end else begin
         m_value = num_bins_ff;
      end
   end

   assign full = total_ff == CNT_W'(MAX_SAMPLES);

   always_comb begin
      case (req_type)
         REQ_LOAD: begin
            pre_status = full ? ST_FULL : ST_OK;
         end
         REQ_BIN: begin
            if (!ready_ff) begin
               pre_status = ST_NOHIST;
            end else if ({1'b0, req_bin_index} >= m_value) begin
               pre_status = ST_RANGE;
            end else begin
               pre_status = ST_OK;
            end
         end
         REQ_PIXEL: begin
            if (!ready_ff) begin
               pre_status = ST_NOHIST;
            end else if (req_pixel_row >= img_wid_ff || req_pixel_col >= img_len_ff) begin
               pre_status = ST_RANGE;
            end else begin
               pre_status = ST_OK;
            end
         end
         default: pre_status = ST_RANGE;
      endcase
   end

   assign store_we = cmd.accept && (req_type == REQ_LOAD) && !full;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[total_ff[SA_W-1:0]] <= req_sample_value;
      end
      store_rdata_ff <= store_mem[idx_ff[SA_W-1:0]];
   end

   always_comb begin
      if (span_zero_ff) begin
         bin_q = '0;
      end else if (quo >= {1'b0, m_value}) begin
         bin_q = {1'b0, m_value} - 1'b1;
      end else begin
         bin_q = quo;
      end
   end

   assign inc_count   = bin_rdata_ff + 1'b1;
   assign bin_rd_addr = cmd.bin_rd_bar ?
                        ((type_ff == REQ_PIXEL) ? BIN_W'(quo) : BIN_W'(bidx_ff)) :
                        BIN_W'(bin_q);
   assign bin_we      = cmd.clr_step || cmd.bc_write;
   assign bin_wr_addr = cmd.clr_step ? clr_ff : BIN_W'(bin_q);
   assign bin_wr_data = cmd.clr_step ? '0 : inc_count;

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_wr_addr] <= bin_wr_data;
      end
      bin_rdata_ff <= bin_mem[bin_rd_addr];
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_BIN: begin
            div_num = prod_ff;
            div_den = span_ff;
         end
         DIV_BAR: begin
            div_num = NUM_W'({bprod_ff, 2'b00}) + NUM_W'(den5_ff) - NUM_W'(1);
            div_den = DEN_W'(den5_ff);
         end
         DIV_STRIPE: begin
            div_num = NUM_W'(img_wid_ff);
            div_den = DEN_W'(m_value);
         end
         default: begin
            div_num = NUM_W'(row_ff);
            div_den = DEN_W'(quo);
         end
      endcase
   end

   hbie_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (quo),
      .done  (div_done)
   );

   assign off_full  = {store_rdata_ff[31], store_rdata_ff} - {lo_ff[31], lo_ff};
   assign span_full = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};

   always_comb begin
      if (peak_ff == '0) begin
         bar_h = '0;
      end else if (quo > img_wid_ff) begin
         bar_h = img_wid_ff;
      end else begin
         bar_h = quo;
      end
   end

   always_comb begin
      num_bins_in  = num_bins_ff;
      img_len_in   = img_len_ff;
      img_wid_in   = img_wid_ff;
      ready_in     = ready_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      peak_in      = peak_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      span_zero_in = span_zero_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      bprod_in     = bprod_ff;
      den5_in      = den5_ff;
      type_in      = type_ff;
      bidx_in      = bidx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      full_st_in   = full_st_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      count_in     = count_ff;
      height_in    = height_ff;
      pixel_in     = pixel_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_NUM_BINS: begin
               num_bins_in = csr_wdata[8:0];
               ready_in    = 1'b0;
            end
            CSR_IMG_LEN: img_len_in = csr_wdata;
            CSR_IMG_WID: img_wid_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         type_in    = req_type;
         bidx_in    = req_bin_index;
         row_in     = req_pixel_row;
         col_in     = req_pixel_col;
         full_st_in = full;
      end
      if (store_we) begin
         total_in = total_ff + 1'b1;
      end

      if (cmd.clr_step) begin
         clr_in  = clr_ff + 1'b1;
         lo_in   = '0;
         hi_in   = '0;
         peak_in = '0;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.mm_upd) begin
         if (idx_ff == '0) begin
            lo_in = store_rdata_ff;
            hi_in = store_rdata_ff;
         end else begin
            if ($signed(store_rdata_ff) < $signed(lo_ff)) begin
               lo_in = store_rdata_ff;
            end
            if ($signed(store_rdata_ff) > $signed(hi_ff)) begin
               hi_in = store_rdata_ff;
            end
         end
      end
      if (cmd.bn_off) begin
         off_in       = off_full[31:0];
         span_in      = span_full[31:0];
         span_zero_in = hi_ff == lo_ff;
      end
      if (cmd.bn_mul) begin
         prod_in = {9'b0, off_ff} * {32'b0, m_value};
      end
      if (cmd.bc_write && (inc_count > peak_ff)) begin
         peak_in = inc_count;
      end
      if (cmd.finish) begin
         ready_in = 1'b1;
         total_in = '0;
      end
      if (cmd.br_mul) begin
         cnt_in   = bin_rdata_ff;
         bprod_in = BP_W'(bin_rdata_ff) * BP_W'(img_len_ff);
         den5_in  = D5_W'({peak_ff, 2'b00}) + D5_W'(peak_ff);
      end

      case (cmd.rsp_op)
         RSP_PRE: begin
            strobe_in = 1'b1;
            status_in = pre_status;
            count_in  = '0;
            height_in = '0;
            pixel_in  = '0;
         end
         RSP_LOAD: begin
            strobe_in = 1'b1;
            status_in = full_st_ff ? ST_FULL : ST_OK;
            count_in  = '0;
            height_in = '0;
            pixel_in  = '0;
         end
         RSP_BLANK: begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            count_in  = '0;
            height_in = '0;
            pixel_in  = PIX_BACKGROUND;
         end
         RSP_BAR: begin
            strobe_in = 1'b1;
            status_in = ST_OK;
            height_in = bar_h;
            if (type_ff == REQ_PIXEL) begin
               count_in = '0;
               pixel_in = ({1'b0, col_ff} < {1'b0, bar_h}) ? PIX_INSIDE : PIX_BACKGROUND;
            end else begin
               count_in = cnt_ff;
               pixel_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      off_ff       <= off_in;
      span_ff      <= span_in;
      span_zero_ff <= span_zero_in;
      prod_ff      <= prod_in;
      cnt_ff       <= cnt_in;
      bprod_ff     <= bprod_in;
      den5_ff      <= den5_in;
      type_ff      <= type_in;
      bidx_ff      <= bidx_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      full_st_ff   <= full_st_in;
      status_ff    <= status_in;
      count_ff     <= count_in;
      height_ff    <= height_in;
      pixel_ff     <= pixel_in;
      if (reset) begin
         num_bins_ff <= 9'(NUM_BINS_RST);
         img_len_ff  <= 10'(IMG_LEN_RST);
         img_wid_ff  <= 10'(IMG_WID_RST);
         ready_ff    <= 1'b0;
         total_ff    <= '0;
         idx_ff      <= '0;
         clr_ff      <= '0;
         lo_ff       <= '0;
         hi_ff       <= '0;
         peak_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         num_bins_ff <= num_bins_in;
         img_len_ff  <= img_len_in;
         img_wid_ff  <= img_wid_in;
         ready_ff    <= ready_in;
         total_ff    <= total_in;
         idx_ff      <= idx_in;
         clr_ff      <= (cmd.clr_step && (clr_ff == BIN_W'(MAX_BINS - 1))) ? '0 : clr_in;
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         peak_ff     <= peak_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_comb begin
      st.req_type    = req_type;
      st.last        = req_last_sample;
      st.pre_status  = pre_status;
      st.total_zero  = total_ff == '0;
      st.idx_last    = (idx_ff + 1'b1) == total_ff;
      st.clr_last    = clr_ff == BIN_W'(MAX_BINS - 1);
      st.span_zero   = span_zero_ff;
      st.peak_zero   = peak_ff == '0;
      st.stripe_zero = quo == '0;
      st.k_out       = quo >= {1'b0, m_value};
      st.div_done    = div_done;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_bin_count   = count_ff;
   assign rsp_bar_height  = height_ff;
   assign rsp_pixel_value = pixel_ff;
   assign rsp_min_value   = lo_ff;
   assign rsp_max_value   = hi_ff;
   assign rsp_max_count   = peak_ff;

endmodule

// File: hdl/hbie_ctrl.sv
// sequencer for loads, the histogram pass and read requests
module hbie_ctrl
   import hbie_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [18:0] {
      S_IDLE    = 19'b0000000000000000001,
      S_CLR     = 19'b0000000000000000010,
      S_MM_RD   = 19'b0000000000000000100,
      S_MM_UPD  = 19'b0000000000000001000,
      S_BN_RD   = 19'b0000000000000010000,
      S_BN_OFF  = 19'b0000000000000100000,
      S_BN_MUL  = 19'b0000000000001000000,
      S_BN_GO   = 19'b0000000000010000000,
      S_BN_DIV  = 19'b0000000000100000000,
      S_BC_RD   = 19'b0000000001000000000,
      S_BC_WR   = 19'b0000000010000000000,
      S_FIN     = 19'b0000000100000000000,
      S_BR_RD   = 19'b0000001000000000000,
      S_BR_MUL  = 19'b0000010000000000000,
      S_BR_GO   = 19'b0000100000000000000,
      S_BR_DIV  = 19'b0001000000000000000,
      S_BR_OUT  = 19'b0010000000000000000,
      S_PX_SDIV = 19'b0100000000000000000,
      S_PX_KDIV = 19'b1000000000000000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (st.req_type)
                  REQ_LOAD: begin
                     if (st.last) begin
                        state_in = S_CLR;
                     end else begin
                        cmd.rsp_op = RSP_PRE;
                     end
                  end
                  REQ_BIN: begin
                     if (st.pre_status != ST_OK) begin
                        cmd.rsp_op = RSP_PRE;
                     end else begin
                        state_in = S_BR_RD;
                     end
                  end
                  REQ_PIXEL: begin
                     if (st.pre_status != ST_OK) begin
                        cmd.rsp_op = RSP_PRE;
                     end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_STRIPE;
                        state_in      = S_PX_SDIV;
                     end
                  end
                  default: cmd.rsp_op = RSP_PRE;
               endcase
            end
         end
         S_CLR: begin
            cmd.clr_step  = 1'b1;
            cmd.idx_clear = 1'b1;
            if (st.clr_last) begin
               state_in = st.total_zero ? S_FIN : S_MM_RD;
            end
         end
         S_MM_RD: state_in = S_MM_UPD;
         S_MM_UPD: begin
            cmd.mm_upd = 1'b1;
            if (st.idx_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = S_BN_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_MM_RD;
            end
         end
         S_BN_RD: state_in = S_BN_OFF;
         S_BN_OFF: begin
            cmd.bn_off = 1'b1;
            state_in   = S_BN_MUL;
         end
         S_BN_MUL: begin
            cmd.bn_mul = 1'b1;
            state_in   = st.span_zero ? S_BC_RD : S_BN_GO;
         end
         S_BN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BIN;
            state_in      = S_BN_DIV;
         end
         S_BN_DIV: begin
            if (st.div_done) begin
               state_in = S_BC_RD;
            end
         end
         S_BC_RD: state_in = S_BC_WR;
         S_BC_WR: begin
            cmd.bc_write = 1'b1;
            if (st.idx_last) begin
               state_in = S_FIN;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_BN_RD;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            cmd.rsp_op = RSP_LOAD;
            state_in   = S_IDLE;
         end
         S_BR_RD: begin
            cmd.bin_rd_bar = 1'b1;
            state_in       = S_BR_MUL;
         end
         S_BR_MUL: begin
            cmd.br_mul = 1'b1;
            state_in   = st.peak_zero ? S_BR_OUT : S_BR_GO;
         end
         S_BR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BAR;
            state_in      = S_BR_DIV;
         end
         S_BR_DIV: begin
            if (st.div_done) begin
               state_in = S_BR_OUT;
            end
         end
         S_BR_OUT: begin
            cmd.rsp_op = RSP_BAR;
            state_in   = S_IDLE;
         end
         S_PX_SDIV: begin
            if (st.div_done) begin
               if (st.stripe_zero) begin
                  cmd.rsp_op = RSP_BLANK;
                  state_in   = S_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_ROW;
                  state_in      = S_PX_KDIV;
               end
            end
         end
         S_PX_KDIV: begin
            if (st.div_done) begin
               if (st.k_out) begin
                  cmd.rsp_op = RSP_BLANK;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_BR_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/histogram_bar_image_engine_core.sv
// top level of the min/max normalized histogram and bar image engine
//
// requests: a transaction is taken on a clock edge with start high and busy low.
// req_type selects load sample, read bin or read pixel; every transaction gives
// exactly one result, shown for one cycle with rsp_strobe high.
// a load without last_sample answers in the next cycle and busy stays low,
// so loads stream at one per cycle into the sample store.
// a load with last_sample runs the histogram pass: a clear of MAX_BINS bin
// counters, a read and an update per stored sample for min/max, then for each
// sample an offset, a multiply, a division in the bit-serial divider (skipped
// when all samples are equal) and a read-modify-write of the bin counter memory.
// a read bin uses the serial divider once for the bar, a read pixel twice more
// for stripe and row. errors answer in the next cycle without raising busy,
// except a full store on a load with last_sample, which answers after the pass.
// configuration writes on csr_we are taken at once; write only while idle.
// synchronous reset empties the store, drops the histogram and loads the
// register defaults; the bin counters are cleared by each histogram pass.
// results cannot be held off by the receiver.
module histogram_bar_image_engine_core
   import hbie_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int MAX_BINS    = 256
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [31:0]                         req_sample_value,
   input  logic                                req_last_sample,
   input  logic [7:0]                          req_bin_index,
   input  logic [9:0]                          req_pixel_row,
   input  logic [9:0]                          req_pixel_col,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [9:0]                          csr_wdata,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic [$clog2(MAX_SAMPLES + 1)-1:0]  rsp_bin_count,
   output logic [9:0]                          rsp_bar_height,
   output logic [7:0]                          rsp_pixel_value,
   output logic [31:0]                         rsp_min_value,
   output logic [31:0]                         rsp_max_value,
   output logic [$clog2(MAX_SAMPLES + 1)-1:0]  rsp_max_count
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   cmd_type  cmd;
   stat_type st;

   hbie_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   hbie_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_BINS    (MAX_BINS),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .req_bin_index    (req_bin_index),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_bar_height   (rsp_bar_height),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_count    (rsp_max_count)
   );

endmodule

// File: hdl/hbie_checker.sv
// port level checks of the histogram engine, bound to the top level
module hbie_checker
   import hbie_pkg::*;
#(
   parameter int CNT_W = 13
)
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_type,
   input logic             req_last_sample,
   input logic             rsp_strobe,
   input logic [1:0]       rsp_status,
   input logic [CNT_W-1:0] rsp_bin_count,
   input logic [9:0]       rsp_bar_height,
   input logic [CNT_W-1:0] rsp_max_count
);

   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_LOAD) && !req_last_sample |=> rsp_strobe)
      else $error("plain load transaction gave no result in the next cycle");

   a_last_starts_pass: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == REQ_LOAD) && req_last_sample |=> busy)
      else $error("last sample did not start the histogram pass");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK) |-> (rsp_bin_count == '0) && (rsp_bar_height == '0))
      else $error("error result carries data");

   a_blank_without_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_max_count == '0) |-> rsp_bar_height == '0)
      else $error("bar height with zero peak count");

endmodule

bind histogram_bar_image_engine_core hbie_checker #(
   .CNT_W ($clog2(MAX_SAMPLES + 1))
) u_hbie_checker (.*);

// File: dv/histogram_bar_image_engine_core_tb.sv
// testbench of the histogram bar image engine: predicts every response and checks it
`timescale 1ns / 1ps

module histogram_bar_image_engine_core_tb;
   import hbie_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int BIN_DEPTH   = 256;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct {
      status_type  status;
      int unsigned count;
      int unsigned height;
      int unsigned pixel;
      logic [31:0] min_v;
      logic [31:0] max_v;
      int unsigned peak;
   } hist_rsp_type;

   class hist_scoreboard;
      logic [31:0]  store[STORE_DEPTH];
      int unsigned  total;
      int unsigned  counts[BIN_DEPTH];
      logic [31:0]  lowest;
      logic [31:0]  highest;
      int unsigned  peak;
      bit           ready;
      int unsigned  nbins;
      int unsigned  ilen;
      int unsigned  iwid;
      hist_rsp_type exp_q[$];
      int           errors;

      function new();
         total = 0;
         foreach (counts[i]) counts[i] = 0;
         lowest = 0;
         highest = 0;
         peak = 0;
         ready = 0;
         nbins = NUM_BINS_RST;
         ilen = IMG_LEN_RST;
         iwid = IMG_WID_RST;
         errors = 0;
      endfunction

      function void write_csr(csr_index_type idx, int unsigned value);
         case (idx)
            CSR_NUM_BINS: begin
               nbins = value & 'h1ff;
               ready = 0;
            end
            CSR_IMG_LEN: ilen = value & 'h3ff;
            CSR_IMG_WID: iwid = value & 'h3ff;
            default: ;
         endcase
      endfunction

      function int unsigned bins_used();
         if (nbins == 0) return 1;
         if (nbins > BIN_DEPTH) return BIN_DEPTH;
         return nbins;
      endfunction

      function void build_histogram();
         int unsigned m;
         longint lo;
         longint hi;
         longint x;
         longint span;
         longint b;
         m = bins_used();
         lo = 0;
         hi = 0;
         if (total > 0) begin
            lo = longint'($signed(store[0]));
            hi = lo;
         end
         for (int i = 1; i < total; i++) begin
            x = longint'($signed(store[i]));
            if (x < lo) lo = x;
            if (x > hi) hi = x;
         end
         foreach (counts[i]) counts[i] = 0;
         span = hi - lo;
         for (int i = 0; i < total; i++) begin
            b = 0;
            if (span != 0) begin
               b = ((longint'($signed(store[i])) - lo) * m) / span;
               if (b >= m) b = m - 1;
            end
            counts[b]++;
         end
         peak = 0;
         foreach (counts[i]) if (counts[i] > peak) peak = counts[i];
         lowest = lo[31:0];
         highest = hi[31:0];
         ready = 1;
         total = 0;
      endfunction

      function int unsigned bar_height(int unsigned k);
         longint num;
         longint den;
         longint h;
         if (peak == 0 || k >= BIN_DEPTH) return 0;
         num = longint'(counts[k]) * 4 * ilen;
         den = 5 * longint'(peak);
         h = (num + den - 1) / den;
         if (h > iwid) h = iwid;
         return int'(h);
      endfunction

      function void note_request(logic [1:0] kind, logic [31:0] sample, logic last,
                                 int unsigned bidx, int unsigned row, int unsigned col);
         hist_rsp_type r;
         int unsigned  m;
         int unsigned  stripe;
         int unsigned  k;
         m = bins_used();
         r.status = ST_OK;
         r.count = 0;
         r.height = 0;
         r.pixel = 0;
         if (kind == REQ_LOAD) begin
            if (total < STORE_DEPTH) begin
               store[total] = sample;
               total++;
            end else begin
               r.status = ST_FULL;
            end
            if (last) build_histogram();
         end else if (kind == REQ_BIN) begin
            if (!ready) r.status = ST_NOHIST;
            else if (bidx >= m) r.status = ST_RANGE;
            else begin
               r.count = counts[bidx];
               r.height = bar_height(bidx);
            end
         end else if (kind == REQ_PIXEL) begin
            if (!ready) r.status = ST_NOHIST;
            else if (row >= iwid || col >= ilen) r.status = ST_RANGE;
            else begin
               stripe = iwid / m;
               r.pixel = 255;
               if (stripe != 0) begin
                  k = row / stripe;
                  if (k < m) begin
                     r.height = bar_height(k);
                     if (col < r.height) r.pixel = 0;
                  end
               end
            end
         end else begin
            r.status = ST_RANGE;
         end
         r.min_v = lowest;
         r.max_v = highest;
         r.peak = peak;
         exp_q.push_back(r);
      endfunction

      function void check_response(logic [1:0] status, logic [12:0] count,
                                   logic [9:0] height, logic [7:0] pixel,
                                   logic [31:0] min_v, logic [31:0] max_v,
                                   logic [12:0] peak_v);
         hist_rsp_type e;
         if (exp_q.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
            return;
         end
         e = exp_q.pop_front();
         if (status != e.status) begin
            $error("status: expected %0d actual %0d", e.status, status);
            errors++;
         end
         if (count != e.count[12:0]) begin
            $error("bin_count: expected %0d actual %0d", e.count, count);
            errors++;
         end
         if (height != e.height[9:0]) begin
            $error("bar_height: expected %0d actual %0d", e.height, height);
            errors++;
         end
         if (pixel != e.pixel[7:0]) begin
            $error("pixel_value: expected %0d actual %0d", e.pixel, pixel);
            errors++;
         end
         if (min_v != e.min_v) begin
            $error("min_value: expected %0d actual %0d", $signed(e.min_v), $signed(min_v));
            errors++;
         end
         if (max_v != e.max_v) begin
            $error("max_value: expected %0d actual %0d", $signed(e.max_v), $signed(max_v));
            errors++;
         end
         if (peak_v != e.peak[12:0]) begin
            $error("max_count: expected %0d actual %0d", e.peak, peak_v);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_LOAD;
   logic [31:0] req_sample_value = '0;
   logic        req_last_sample = 1'b0;
   logic [7:0]  req_bin_index = '0;
   logic [9:0]  req_pixel_row = '0;
   logic [9:0]  req_pixel_col = '0;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_NUM_BINS;
   logic [9:0]  csr_wdata = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_bin_count;
   logic [9:0]  rsp_bar_height;
   logic [7:0]  rsp_pixel_value;
   logic [31:0] rsp_min_value;
   logic [31:0] rsp_max_value;
   logic [12:0] rsp_max_count;

   hist_scoreboard sb = new();
   int  items_sent = 0;
   bit  gaps_on = 1;

   histogram_bar_image_engine_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .req_bin_index    (req_bin_index),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_bar_height   (rsp_bar_height),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_count    (rsp_max_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_response(rsp_status, rsp_bin_count, rsp_bar_height, rsp_pixel_value,
                           rsp_min_value, rsp_max_value, rsp_max_count);
      end
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic [1:0] kind, logic [31:0] sample, logic last,
                       logic [7:0] bidx, logic [9:0] row, logic [9:0] col, int gap);
      start <= 1'b1;
      req_type <= kind;
      req_sample_value <= sample;
      req_last_sample <= last;
      req_bin_index <= bidx;
      req_pixel_row <= row;
      req_pixel_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, sample, last, bidx, row, col);
      items_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.exp_q.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[9:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_csr(idx, value);
   endtask

   function automatic logic [31:0] pick_sample(int mode, logic [31:0] base);
      case (mode)
         0: return $urandom();
         1: return base + $urandom_range(0, 40);
         2: return base;
         default: begin
            case ($urandom_range(0, 2))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   task automatic load_set(int n);
      int          mode;
      logic [31:0] base;
      mode = $urandom_range(0, 3);
      base = $urandom();
      for (int i = 0; i < n; i++) begin
         send(REQ_LOAD, pick_sample(mode, base), i == n - 1, 8'($urandom()),
              10'($urandom()), 10'($urandom()), pick_gap());
      end
   endtask

   task automatic read_some(int n);
      int unsigned m;
      m = sb.bins_used();
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send(REQ_BIN, $urandom(), 1'($urandom()),
                             8'($urandom_range(0, m + 1)), 10'($urandom()),
                             10'($urandom()), pick_gap());
            4, 5, 6, 7: send(REQ_PIXEL, $urandom(), 1'($urandom()), 8'($urandom()),
                             10'($urandom_range(0, sb.iwid)),
                             10'($urandom_range(0, sb.ilen)), pick_gap());
            8: send(REQ_UNKNOWN, $urandom(), 1'($urandom()), 8'($urandom()),
                    10'($urandom()), 10'($urandom()), pick_gap());
            default: send(2'($urandom_range(1, 2)), $urandom(), 1'($urandom()),
                          8'($urandom()), 10'($urandom()), 10'($urandom()), pick_gap());
         endcase
      end
   endtask

   function automatic int unsigned pick_bins();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 2;
         3: return 255;
         4: return 256;
         5: return $urandom_range(257, 511);
         default: return $urandom_range(1, 256);
      endcase
   endfunction

   function automatic int unsigned pick_extent();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 1023;
         3: return 1022;
         default: return $urandom_range(2, 1023);
      endcase
   endfunction

   initial begin
      int sets;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reads before any histogram, unknown request
      gaps_on = 0;
      send(REQ_BIN, 0, 0, 0, 0, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 0, 0, 0);
      send(REQ_UNKNOWN, 0, 0, 0, 0, 0, 0);
      // extremes in one set with default registers
      send(REQ_LOAD, 32'h8000_0000, 0, 8'hff, 10'h3ff, 10'h3ff, 0);
      send(REQ_LOAD, 32'h7fff_ffff, 0, 0, 0, 0, 0);
      send(REQ_LOAD, 32'h0000_0000, 1, 0, 0, 0, 0);
      send(REQ_BIN, 0, 0, 0, 0, 0, 0);
      send(REQ_BIN, 0, 0, 99, 0, 0, 0);
      send(REQ_BIN, 0, 0, 100, 0, 0, 0);
      send(REQ_BIN, 0, 0, 8'hff, 0, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 0, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 299, 299, 0);
      send(REQ_PIXEL, 0, 0, 0, 300, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 0, 300, 0);
      // all samples equal
      send(REQ_LOAD, 32'hffff_fff6, 0, 0, 0, 0, 0);
      send(REQ_LOAD, 32'hffff_fff6, 1, 0, 0, 0, 0);
      send(REQ_BIN, 0, 0, 0, 0, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 1, 5, 0);
      drain();

      // full store, then the overflowing loads
      write_csr(CSR_NUM_BINS, 3);
      write_csr(CSR_IMG_LEN, 1023);
      write_csr(CSR_IMG_WID, 1023);
      send(REQ_BIN, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < STORE_DEPTH; i++) send(REQ_LOAD, $urandom(), 0, 0, 0, 0, 0);
      send(REQ_LOAD, $urandom(), 0, 0, 0, 0, 0);
      send(REQ_LOAD, $urandom(), 1, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) send(REQ_BIN, 0, 0, 8'(i), 0, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 1022, 1022, 0);
      send(REQ_PIXEL, 0, 0, 0, 1023, 0, 0);
      drain();

      // stripe height zero
      write_csr(CSR_IMG_WID, 2);
      write_csr(CSR_NUM_BINS, 256);
      send(REQ_LOAD, 5, 0, 0, 0, 0, 0);
      send(REQ_LOAD, 9, 1, 0, 0, 0, 0);
      send(REQ_PIXEL, 0, 0, 0, 1, 0, 0);
      send(REQ_BIN, 0, 0, 255, 0, 0, 0);
      drain();

      items_sent = 0;
      sets = 0;
      while (items_sent < 1900) begin
         if (sets % 6 == 0) begin
            drain();
            write_csr(CSR_IMG_LEN, pick_extent());
            write_csr(CSR_IMG_WID, pick_extent());
            if ($urandom_range(0, 3) != 0) write_csr(CSR_NUM_BINS, pick_bins());
            read_some(2);
            gaps_on = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 19) == 0) load_set($urandom_range(100, 300));
         else load_set($urandom_range(1, 30));
         read_some($urandom_range(3, 15));
         sets++;
      end
      drain();
      repeat (100) @(posedge clock);
      if (sb.exp_q.size() != 0) begin
         $error("%0d transactions without response", sb.exp_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
